### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/hvss_pkg.sv
// Package: widths, constants, register indexes and divider types of the step scaler.
`default_nettype none

package hvss_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int IDLE_DECAY_MS = 120;
    localparam int CNT_W         = (COUNT_BITS > 32) ? 32 : COUNT_BITS;

    localparam int COUNT_W    = 32;
    localparam int TIME_W     = 32;
    localparam int PULSE_W    = 30;
    localparam int PEND_W     = 32;
    localparam int SPEED_W    = 24;
    localparam int STEP_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int BASE_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int INST_W   = 26;
    localparam int SMOOTH_W = 28;
    localparam int DECAY_W  = 29;

    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_REM_W = 32;
    localparam int DIV_LO_W  = 26;
    localparam int DIV_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG_INV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP  = 3'd4;

    localparam logic [SPEED_W-1:0] RST_VEL_LOW   = 24'd1280;
    localparam logic [SPEED_W-1:0] RST_VEL_HIGH  = 24'd12800;
    localparam logic [SCALE_W-1:0] RST_SCALE_MAX = 16'd40960;
    localparam logic [BASE_W-1:0]  RST_BASE_STEP = 24'd655;

    localparam logic [PULSE_W-1:0]  PULSE_MAX   = {1'b0, {(PULSE_W-1){1'b1}}};
    localparam logic [PEND_W-1:0]   PEND_MAX    = {1'b0, {(PEND_W-1){1'b1}}};
    localparam logic [PEND_W-1:0]   PEND_MIN    = {1'b1, {(PEND_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0]  ONE_Q12     = 16'd4096;
    localparam logic [SPEED_W-1:0]  SPEED_MAX   = {SPEED_W{1'b1}};
    localparam logic [SPEED_W-1:0]  SPEED_FLOOR = 24'd128;
    localparam logic [MUL_B_W-1:0]  INST_GAIN   = 27'd256000;
    localparam logic [INST_W-1:0]   INST_SAT    = {INST_W{1'b1}};
    localparam logic [SMOOTH_W-1:0] SMOOTH_SAT  = 28'd83886080;

    // ceil(2^29 / 5): exact floor(x / 5) for x below 2^29 / 3
    localparam logic [MUL_B_W-1:0]  RECIP_5     = 27'd107374183;
    localparam int                  RECIP_SHIFT = 29;

    localparam logic [DIV_CNT_W-1:0] INST_STEPS   = 5'd26;
    localparam logic [DIV_CNT_W-1:0] INTERP_STEPS = 5'd16;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_REM_W-1:0] rem0;
        logic [DIV_LO_W-1:0]  lo;
        logic [DIV_REM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_LO_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/core/hvss_in_if.sv
// Interface: input word channel (sample or consume request).
`default_nettype none

interface hvss_in_if import hvss_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [COUNT_W-1:0] encoder_count;
    logic [TIME_W-1:0]         now_ms;

    modport source (output valid, output func, output encoder_count, output now_ms,
                    input ready);
    modport sink (input valid, input func, input encoder_count, input now_ms,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/hvss_out_if.sv
// Interface: result word channel.
`default_nettype none

interface hvss_out_if import hvss_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [PULSE_W-1:0] pulses;
    logic signed [PEND_W-1:0]  pending_pulses;
    logic [SPEED_W-1:0]        velocity;
    logic [STEP_W-1:0]         step_size;

    modport source (output valid, output pulses, output pending_pulses, output velocity,
                    output step_size, input ready);
    modport sink (input valid, input pulses, input pending_pulses, input velocity,
                  input step_size, output ready);
endinterface

`default_nettype wire

### rtl/core/handwheel_velocity_step_scaler.sv
// Top level: handwheel sample sequencer with shared multiplier and divider.
//
// Each input word is either a sample (func 0) or a consume (func 1) and
// yields one result word. A consume goes from decode straight to the done
// state; a sample without pulses updates and, when the idle decay runs,
// waits on the reciprocal multiply. For a sample with pulses, the rate
// divide (26 quotient bits) and the scale interpolation divide (16 quotient
// bits) run on one shared radix-2 divider, and all products, including the
// reciprocal multiplies for the divides by 5 and by 20, share one registered
// multiplier. A saturated rate or a scale at either end skips its divide.
// The input is not ready until the result is loaded into the output
// register; a finished result waits there while the next word is taken.
// Configuration words must be written while the block is idle, unenforced.
`default_nettype none

module handwheel_velocity_step_scaler import hvss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hvss_in_if.sink               i_in,
    hvss_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_UPDATE, S_INST, S_INST_W, S_SMOOTH, S_SMOOTH_W,
        S_SCALE, S_INTERP, S_INTERP_W, S_STEP, S_STEP_W, S_DECAY_W, S_DONE
    } t_state;

    t_state r_state;

    logic               r_sig_inv;
    logic [SPEED_W-1:0] r_vel_low;
    logic [SPEED_W-1:0] r_vel_high;
    logic [SCALE_W-1:0] r_scale_max;
    logic [BASE_W-1:0]  r_base_step;

    logic [COUNT_W-1:0] r_last;
    logic [PEND_W-1:0]  r_pend;
    logic [SPEED_W-1:0] r_v;
    logic [TIME_W-1:0]  r_lpt;
    logic [STEP_W-1:0]  r_step;

    logic               r_func;
    logic [COUNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]  r_now;
    logic [PULSE_W-1:0] r_p;
    logic [PULSE_W-1:0] r_ap;
    logic [TIME_W-1:0]  r_dt;
    logic [INST_W-1:0]  r_inst;
    logic [SCALE_W-1:0] r_scale;

    logic               r_ov;
    logic [PULSE_W-1:0] r_o_pulses;
    logic [PEND_W-1:0]  r_o_pend;
    logic [SPEED_W-1:0] r_o_vel;
    logic [STEP_W-1:0]  r_o_step;

    logic [CNT_W-1:0]    w_diff;
    logic [CNT_W-1:0]    w_mag;
    logic                w_dneg;
    logic                w_neg;
    logic [PULSE_W-1:0]  w_q;
    logic [PULSE_W-1:0]  w_pmag;
    logic [PULSE_W-1:0]  w_p;
    logic [PEND_W:0]     w_sum;
    logic [PEND_W-1:0]   w_pend_sat;
    logic [TIME_W-1:0]   w_since;
    logic                w_decay_go;
    logic [SMOOTH_W-1:0] w_x;
    logic                w_smooth_sat;
    logic [DECAY_W-1:0]  w_y;
    logic [SPEED_W-1:0]  w_recip_q;
    logic                w_inst_sat;
    logic [SCALE_W-1:0]  w_smax;
    logic [SPEED_W-1:0]  w_vdiff;
    logic [SPEED_W-1:0]  w_vspan;
    logic [SCALE_W-1:0]  w_sdiff;
    logic [SCALE_W-1:0]  w_iscale;
    logic                w_out_free;

    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    hvss_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    hvss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // pulse decode
    assign w_diff = r_cnt[CNT_W-1:0] - r_last[CNT_W-1:0];
    assign w_dneg = w_diff[CNT_W-1];
    assign w_mag  = w_dneg ? (CNT_W'(0) - w_diff) : w_diff;
    assign w_q    = PULSE_W'(w_mag >> 2);
    assign w_neg  = w_dneg ^ r_sig_inv;
    assign w_pmag = (!w_neg && (w_q > PULSE_MAX)) ? PULSE_MAX : w_q;
    assign w_p    = w_neg ? (PULSE_W'(0) - w_pmag) : w_pmag;

    // saturating pending total
    assign w_sum      = {r_pend[PEND_W-1], r_pend} + {{(PEND_W+1-PULSE_W){r_p[PULSE_W-1]}}, r_p};
    assign w_pend_sat = (w_sum[PEND_W] != w_sum[PEND_W-1]) ?
                        (w_sum[PEND_W] ? PEND_MIN : PEND_MAX) : w_sum[PEND_W-1:0];

    assign w_since    = r_now - r_lpt;
    assign w_decay_go = (w_since > TIME_W'(IDLE_DECAY_MS));

    assign w_inst_sat   = ({11'b0, w_prod[46:26]} >= r_dt);
    assign w_x          = {4'b0, r_v} + {3'b0, r_v, 1'b0} + {1'b0, r_inst, 1'b0};
    assign w_smooth_sat = (w_x >= SMOOTH_SAT);
    assign w_y          = {5'b0, r_v} + {1'b0, r_v, 4'b0};
    assign w_recip_q    = w_prod[RECIP_SHIFT +: SPEED_W];

    assign w_smax   = (r_scale_max < ONE_Q12) ? ONE_Q12 : r_scale_max;
    assign w_vdiff  = r_v - r_vel_low;
    assign w_vspan  = r_vel_high - r_vel_low;
    assign w_sdiff  = w_smax - ONE_Q12;
    assign w_iscale = ONE_Q12 + w_div_rsp.quot[SCALE_W-1:0];

    assign w_out_free = !r_ov || o_out.ready;

    always_comb begin
        case (r_state)
            S_UPDATE: begin
                if (r_p != '0) begin
                    w_mul_a = r_ap;
                    w_mul_b = INST_GAIN;
                end else begin
                    w_mul_a = MUL_A_W'(w_y[DECAY_W-1:2]);
                    w_mul_b = RECIP_5;
                end
            end
            S_SMOOTH: begin
                w_mul_a = MUL_A_W'(w_x);
                w_mul_b = RECIP_5;
            end
            S_SCALE: begin
                w_mul_a = MUL_A_W'(w_vdiff);
                w_mul_b = MUL_B_W'(w_sdiff);
            end
            default: begin
                w_mul_a = MUL_A_W'(r_base_step);
                w_mul_b = MUL_B_W'(r_scale);
            end
        endcase
    end

    always_comb begin
        w_div_req = '0;
        case (r_state)
            S_INST: begin
                w_div_req.start   = !w_inst_sat;
                w_div_req.steps   = INST_STEPS;
                w_div_req.rem0    = DIV_REM_W'(w_prod[46:26]);
                w_div_req.lo      = w_prod[25:0];
                w_div_req.divisor = r_dt;
            end
            S_INTERP: begin
                w_div_req.start   = 1'b1;
                w_div_req.steps   = INTERP_STEPS;
                w_div_req.rem0    = DIV_REM_W'(w_prod[39:16]);
                w_div_req.lo      = {w_prod[15:0], 10'b0};
                w_div_req.divisor = DIV_REM_W'(w_vspan);
            end
            default: begin
                w_div_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_inv   <= 1'b0;
            r_vel_low   <= RST_VEL_LOW;
            r_vel_high  <= RST_VEL_HIGH;
            r_scale_max <= RST_SCALE_MAX;
            r_base_step <= RST_BASE_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIG_INV:   r_sig_inv   <= i_cfg_data[0];
                CFG_VEL_LOW:   r_vel_low   <= i_cfg_data[SPEED_W-1:0];
                CFG_VEL_HIGH:  r_vel_high  <= i_cfg_data[SPEED_W-1:0];
                CFG_SCALE_MAX: r_scale_max <= i_cfg_data[SCALE_W-1:0];
                CFG_BASE_STEP: r_base_step <= i_cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_last  <= '0;
            r_pend  <= '0;
            r_v     <= '0;
            r_lpt   <= '0;
            r_step  <= '0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func  <= i_in.func;
                        r_cnt   <= i_in.encoder_count;
                        r_now   <= i_in.now_ms;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_func) begin
                        r_p     <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_p     <= w_p;
                        r_ap    <= w_pmag;
                        r_last  <= r_cnt;
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_p != '0) begin
                        r_pend  <= w_pend_sat;
                        r_lpt   <= r_now;
                        r_dt    <= (w_since == '0) ? TIME_W'(1) : w_since;
                        r_state <= S_INST;
                    end else if (w_decay_go) begin
                        r_step  <= STEP_W'(r_base_step);
                        r_state <= S_DECAY_W;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INST: begin
                    if (w_inst_sat) begin
                        r_inst  <= INST_SAT;
                        r_state <= S_SMOOTH;
                    end else begin
                        r_state <= S_INST_W;
                    end
                end
                S_INST_W: begin
                    if (w_div_rsp.done) begin
                        r_inst  <= w_div_rsp.quot;
                        r_state <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    if (w_smooth_sat) begin
                        r_v     <= SPEED_MAX;
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_SMOOTH_W;
                    end
                end
                S_SMOOTH_W: begin
                    r_v     <= w_recip_q;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_v <= r_vel_low) begin
                        r_scale <= ONE_Q12;
                        r_state <= S_STEP;
                    end else if (r_v >= r_vel_high) begin
                        r_scale <= w_smax;
                        r_state <= S_STEP;
                    end else begin
                        r_state <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    r_state <= S_INTERP_W;
                end
                S_INTERP_W: begin
                    if (w_div_rsp.done) begin
                        r_scale <= w_iscale;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_state <= S_STEP_W;
                end
                S_STEP_W: begin
                    r_step  <= STEP_W'(w_prod[MUL_P_W-1:12]);
                    r_state <= S_DONE;
                end
                S_DECAY_W: begin
                    r_v     <= (w_recip_q < SPEED_FLOOR) ? '0 : w_recip_q;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_pulses <= r_p;
                        r_o_pend   <= r_pend;
                        r_o_vel    <= r_v;
                        r_o_step   <= r_step;
                        if (r_func) begin
                            r_pend <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.pulses         = r_o_pulses;
    assign o_out.pending_pulses = r_o_pend;
    assign o_out.velocity       = r_o_vel;
    assign o_out.step_size      = r_o_step;

    `ASSERT_NEVER(a_div_start_busy, i_clk, i_rst_n,
                  w_div_req.start && w_div_rsp.busy, "divider restarted while busy")
    `ASSERT_CLK(a_div_done_wait, i_clk, i_rst_n,
                w_div_rsp.done |-> (r_state == S_INST_W || r_state == S_INTERP_W),
                "divider result with no waiting state")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n,
                (i_in.valid && i_in.ready) |=> !i_in.ready,
                "input ready right after accepting a word")
    `ASSERT_CLK(a_out_from_done, i_clk, i_rst_n,
                $rose(o_out.valid) |-> $past(r_state == S_DONE),
                "result word loaded outside done state")

endmodule

`default_nettype wire

### rtl/core/hvss_div.sv
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none

module hvss_div import hvss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_LO_W-1:0]  r_lo;
    logic [DIV_REM_W:0]   w_trial;
    logic [DIV_REM_W:0]   w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_lo[DIV_LO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_rem  <= i_req.rem0;
                r_lo   <= i_req.lo;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
                r_lo  <= {r_lo[DIV_LO_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_lo;

endmodule

`default_nettype wire

### rtl/core/hvss_mul.sv
// Shared multiplier with registered product.
`default_nettype none

module hvss_mul import hvss_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_prod;

endmodule

`default_nettype wire
